>>> rtl/dpq_pkg.sv
// dpq_pkg: shared constants, codes and types of the double-ended priority queue
// no dependencies; used by dpq_cell, double_ended_priority_queue, dpq_checker and tb_top
`default_nettype none
package dpq_pkg;

    localparam int DPQ_DEPTH = 128;

    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_REMOVE_MAX = 2'd1,
        OP_REMOVE_MIN = 2'd2,
        OP_SPARE      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE,
        CELL_DROP
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t  mode;
        logic [31:0] value;
        logic [31:0] priority_;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DROP,
        FSM_DONE
    } fsm_t;

endpackage
`default_nettype wire

>>> rtl/dpq_if.sv
// dpq_in_if / dpq_out_if: valid/ready channels of the queue
// depends on nothing but the payload widths of the queue fields
`default_nettype none
interface dpq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
    modport source (output valid, op, item_value, item_priority, input ready);
    modport sink   (input valid, op, item_value, item_priority, output ready);
endinterface

interface dpq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic signed [31:0] removed_priority;
    logic [7:0]         occupancy;
    modport source (output valid, status, removed_value, removed_priority, occupancy,
                    input ready);
    modport sink   (input valid, status, removed_value, removed_priority, occupancy,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/double_ended_priority_queue.sv
// double_ended_priority_queue: insert-ordered cell chain with rotate-scan removal
// insert, empty and full: the result is registered in the cycle after accept
// removal: one ring rotation of the chain finds the extreme priority, a second
// rotation drops it and restores insertion order
// throughput: one request in flight; inserts, empty and full run back to back if
// the result is taken; reset clears the count and all cell valid bits at once
`default_nettype none
module double_ended_priority_queue #(
    parameter int QUEUE_DEPTH = dpq_pkg::DPQ_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dpq_in_if.sink     in_ch,
    dpq_out_if.source  out_ch
);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    logic [QUEUE_DEPTH-1:0] vld;
    logic [31:0]            val_q [QUEUE_DEPTH];
    logic [31:0]            pri_q [QUEUE_DEPTH];
    dpq_pkg::cell_ctrl_t    ctrl;

    dpq_pkg::fsm_t   state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   step_reg, step_next;
    logic [IW-1:0]   best_reg, best_next;
    logic [31:0]     bval_reg, bval_next;
    logic [31:0]     bpri_reg, bpri_next;
    logic            want_max_reg, want_max_next;
    logic            ovalid_reg, ovalid_next;
    logic [1:0]      ostat_reg, ostat_next;
    logic [31:0]     oval_reg, oval_next;
    logic [31:0]     opri_reg, opri_next;
    logic [7:0]      occ_reg, occ_next;
    logic            out_free, in_acc, better;

    // chain of cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        dpq_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .prev_valid    ((i == 0) ? 1'b1 : vld[(i == 0) ? 0 : i - 1]),
            .next_valid    ((i == QUEUE_DEPTH - 1) ? 1'b0 :
                            vld[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .next_value    (val_q[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .next_priority (pri_q[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .head_value    (val_q[0]),
            .head_priority (pri_q[0]),
            .valid         (vld[i]),
            .value         (val_q[i]),
            .priority_     (pri_q[i])
        );
    end

    assign out_free    = !ovalid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == dpq_pkg::FSM_IDLE) && out_free;
    assign in_acc      = in_ch.valid && in_ch.ready;

    // signed compare of the head cell against the best so far
    assign better = want_max_reg ? ($signed(pri_q[0]) > $signed(bpri_reg))
                                 : ($signed(pri_q[0]) < $signed(bpri_reg));

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        step_next     = step_reg;
        best_next     = best_reg;
        bval_next     = bval_reg;
        bpri_next     = bpri_reg;
        want_max_next = want_max_reg;
        ovalid_next   = ovalid_reg && !out_ch.ready;
        ostat_next    = ostat_reg;
        oval_next     = oval_reg;
        opri_next     = opri_reg;
        occ_next      = occ_reg;
        ctrl.mode      = dpq_pkg::CELL_HOLD;
        ctrl.value     = in_ch.item_value;
        ctrl.priority_ = in_ch.item_priority;
        unique case (state_reg)
            dpq_pkg::FSM_IDLE:
            begin
                if (in_acc)
                begin
                    oval_next = '0;
                    opri_next = '0;
                    occ_next  = 8'(cnt_reg);
                    if (in_ch.op == dpq_pkg::OP_INSERT)
                    begin
                        ovalid_next = 1'b1;
                        if (cnt_reg == CW'(QUEUE_DEPTH))
                        begin
                            ostat_next = dpq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.mode  = dpq_pkg::CELL_INSERT;
                            cnt_next   = cnt_reg + 1'b1;
                            occ_next   = 8'(cnt_reg + 1'b1);
                            ostat_next = dpq_pkg::ST_INSERTED;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        ovalid_next = 1'b1;
                        ostat_next  = dpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        want_max_next = (in_ch.op == dpq_pkg::OP_REMOVE_MAX);
                        step_next     = '0;
                        state_next    = dpq_pkg::FSM_SCAN;
                    end
                end
            end
            dpq_pkg::FSM_SCAN:
            begin
                ctrl.mode = dpq_pkg::CELL_ROTATE;
                if (step_reg == '0 || better)
                begin
                    best_next = IW'(step_reg);
                    bval_next = val_q[0];
                    bpri_next = pri_q[0];
                end
                step_next = step_reg + 1'b1;
                if (step_reg == cnt_reg - 1'b1)
                begin
                    step_next  = '0;
                    state_next = dpq_pkg::FSM_DROP;
                end
            end
            dpq_pkg::FSM_DROP:
            begin
                ctrl.mode = (step_reg == CW'(best_reg)) ? dpq_pkg::CELL_DROP
                                                        : dpq_pkg::CELL_ROTATE;
                step_next = step_reg + 1'b1;
                if (step_reg == cnt_reg - 1'b1)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = dpq_pkg::FSM_DONE;
                end
            end
            dpq_pkg::FSM_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = dpq_pkg::ST_REMOVED;
                    oval_next   = bval_reg;
                    opri_next   = bpri_reg;
                    occ_next    = 8'(cnt_reg);
                    state_next  = dpq_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = dpq_pkg::FSM_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dpq_pkg::FSM_IDLE;
            cnt_reg    <= '0;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        bval_reg     <= bval_next;
        bpri_reg     <= bpri_next;
        want_max_reg <= want_max_next;
        ostat_reg    <= ostat_next;
        oval_reg     <= oval_next;
        opri_reg     <= opri_next;
        occ_reg      <= occ_next;
    end

    assign out_ch.valid            = ovalid_reg;
    assign out_ch.status           = ostat_reg;
    assign out_ch.removed_value    = oval_reg;
    assign out_ch.removed_priority = opri_reg;
    assign out_ch.occupancy        = occ_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above depth");
    a_cnt_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dpq_pkg::FSM_IDLE) |-> ($countones(vld) == int'(cnt_reg)))
        else $error("cell valid bits disagree with count");
    a_insert_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_ch.op == dpq_pkg::OP_INSERT) |=> ovalid_reg)
        else $error("insert gave no result");
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != dpq_pkg::FSM_IDLE) |-> !in_ch.ready)
        else $error("input taken while busy");
`endif
endmodule
`default_nettype wire

>>> rtl/dpq_cell.sv
// dpq_cell: one storage cell of the queue chain
// depends on dpq_pkg for the cell control struct
`default_nettype none
module dpq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dpq_pkg::cell_ctrl_t ctrl,
    input  wire logic               prev_valid,
    input  wire logic               next_valid,
    input  wire logic [31:0]        next_value,
    input  wire logic [31:0]        next_priority,
    input  wire logic [31:0]        head_value,
    input  wire logic [31:0]        head_priority,
    output logic                    valid,
    output logic [31:0]             value,
    output logic [31:0]             priority_
);
    logic        valid_reg, valid_next;
    logic [31:0] value_reg, value_next;
    logic [31:0] prio_reg, prio_next;
    logic        last;

    // last occupied cell of the chain wraps to the head
    assign last = valid_reg && !next_valid;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        unique case (ctrl.mode)
            dpq_pkg::CELL_INSERT:
            begin
                if (!valid_reg && prev_valid)
                begin
                    valid_next = 1'b1;
                    value_next = ctrl.value;
                    prio_next  = ctrl.priority_;
                end
            end
            dpq_pkg::CELL_ROTATE:
            begin
                if (valid_reg)
                begin
                    value_next = last ? head_value : next_value;
                    prio_next  = last ? head_priority : next_priority;
                end
            end
            dpq_pkg::CELL_DROP:
            begin
                if (last)
                begin
                    valid_next = 1'b0;
                end
                else if (valid_reg)
                begin
                    value_next = next_value;
                    prio_next  = next_priority;
                end
            end
            default:
            begin
            end
        endcase
    end

    // valid bit resets, payload does not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign valid     = valid_reg;
    assign value     = value_reg;
    assign priority_ = prio_reg;
endmodule
`default_nettype wire

>>> dv/dpq_checker.sv
// dpq_checker: watches both channels of the priority queue, predicts each result
// depends on dpq_pkg and the dpq_in_if / dpq_out_if channel interfaces
`timescale 1ns / 100ps
module dpq_checker #(
    parameter int QUEUE_DEPTH = dpq_pkg::DPQ_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dpq_in_if          in_ch,
    dpq_out_if         out_ch,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        dpq_pkg::status_t status;
        logic [31:0]      value;
        logic [31:0]      prio;
        logic [7:0]       occupancy;
    } outcome_t;

    // shadow of the queue contents in insertion order
    logic signed [31:0] held_value[$];
    logic signed [31:0] held_prio[$];
    outcome_t           expected_q[$];

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // work out the outcome of one request and update the shadow queue
    function automatic outcome_t predict_request(input logic [1:0] op,
                                                 input logic signed [31:0] v,
                                                 input logic signed [31:0] p);
        outcome_t o;
        int best;
        o = '0;
        if (op == dpq_pkg::OP_INSERT)
        begin
            if (held_value.size() >= QUEUE_DEPTH)
            begin
                o.status = dpq_pkg::ST_FULL;
            end
            else
            begin
                held_value.push_back(v);
                held_prio.push_back(p);
                o.status = dpq_pkg::ST_INSERTED;
            end
        end
        else if (held_value.size() == 0)
        begin
            o.status = dpq_pkg::ST_EMPTY;
        end
        else
        begin
            // strict compare keeps the earliest entry on ties
            best = 0;
            for (int i = 1; i < held_value.size(); i++)
            begin
                if (op == dpq_pkg::OP_REMOVE_MAX ? held_prio[i] > held_prio[best]
                                                 : held_prio[i] < held_prio[best])
                    best = i;
            end
            o.value = held_value[best];
            o.prio = held_prio[best];
            held_value.delete(best);
            held_prio.delete(best);
            o.status = dpq_pkg::ST_REMOVED;
        end
        o.occupancy = 8'(held_value.size());
        return o;
    endfunction

    // predict on accepted requests, compare on accepted results
    always @(posedge clk)
    begin
        outcome_t e;
        if (!rst_n)
        begin
            fail_count = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t unexpected result transaction", $time);
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (out_ch.status != e.status)
                        report("status", 32'(out_ch.status), 32'(e.status));
                    if (out_ch.removed_value != e.value)
                        report("removed_value", out_ch.removed_value, e.value);
                    if (out_ch.removed_priority != e.prio)
                        report("removed_priority", out_ch.removed_priority, e.prio);
                    if (out_ch.occupancy != e.occupancy)
                        report("occupancy", 32'(out_ch.occupancy), 32'(e.occupancy));
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(predict_request(in_ch.op, in_ch.item_value,
                                                     in_ch.item_priority));
        end
        pending = expected_q.size();
    end

endmodule

>>> dv/tb_top.sv
// tb_top: drives requests into the priority queue and gives the verdict
// depends on dpq_pkg, the channel interfaces, dpq_checker and the queue itself
`timescale 1ns / 100ps
module tb_top;

    localparam int DEPTH = dpq_pkg::DPQ_DEPTH;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    logic stall_mode = 1'b0;

    dpq_in_if  in_ch();
    dpq_out_if out_ch();

    double_ended_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
    );

    dpq_checker #(.QUEUE_DEPTH(DEPTH)) checker_i (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // priorities from a narrow pool give many ties, the rest span the full range
    function automatic logic [31:0] pick_prio();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return 32'($signed($urandom_range(0, 6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    // present one request and hold it until accepted
    task automatic send_request(input logic [1:0] op, input logic [31:0] v,
                                input logic [31:0] p);
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.item_value <= v;
        in_ch.item_priority <= p;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic idle_gap(input int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // receiver stalls: long ready stretches alternate with choppy phases
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= ~stall_mode;
        out_ch.ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    // stimulus
    initial
    begin
        int burst;
        int fill_bias;
        logic [1:0] op;
        in_ch.valid = 1'b0;
        in_ch.op = dpq_pkg::OP_INSERT;
        in_ch.item_value = '0;
        in_ch.item_priority = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty removals, extremes, ties, spare op code
        send_request(dpq_pkg::OP_REMOVE_MAX, 32'h1234_5678, 32'h7fff_ffff);
        send_request(dpq_pkg::OP_REMOVE_MIN, '1, '1);
        send_request(dpq_pkg::OP_SPARE, '0, '0);
        send_request(dpq_pkg::OP_INSERT, 32'h8000_0000, 32'h8000_0000);
        send_request(dpq_pkg::OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
        send_request(dpq_pkg::OP_INSERT, 32'hffff_ffff, 32'h0000_0000);
        send_request(dpq_pkg::OP_INSERT, 32'h0000_0001, 32'h7fff_ffff);
        send_request(dpq_pkg::OP_INSERT, 32'h0000_0002, 32'h8000_0000);
        send_request(dpq_pkg::OP_INSERT, 32'h5555_aaaa, 32'h0000_0000);
        send_request(dpq_pkg::OP_REMOVE_MAX, '0, '0);
        send_request(dpq_pkg::OP_REMOVE_MIN, '0, '0);
        send_request(dpq_pkg::OP_SPARE, '1, '1);
        send_request(dpq_pkg::OP_REMOVE_MAX, '0, '0);
        send_request(dpq_pkg::OP_REMOVE_MIN, '0, '0);
        send_request(dpq_pkg::OP_REMOVE_MAX, '0, '0);
        send_request(dpq_pkg::OP_REMOVE_MIN, '0, '0);

        // fill to capacity, then overflow
        for (int i = 0; i < DEPTH; i++)
            send_request(dpq_pkg::OP_INSERT, $urandom, pick_prio());
        send_request(dpq_pkg::OP_INSERT, 32'hdead_beef, 32'h1);
        send_request(dpq_pkg::OP_INSERT, 32'haaaa_5555, 32'h2);
        for (int i = 0; i < DEPTH + 1; i++)
            send_request($urandom_range(0, 1) ? dpq_pkg::OP_REMOVE_MAX
                                              : dpq_pkg::OP_REMOVE_MIN, '0, '0);

        // random bursts; the insert bias drifts so occupancy sweeps empty to full
        fill_bias = 50;
        for (int n = 0; n < 2000; n += burst)
        begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0)
                fill_bias = $urandom_range(20, 80);
            for (int k = 0; k < burst; k++)
            begin
                if ($urandom_range(1, 100) <= fill_bias)
                    op = dpq_pkg::OP_INSERT;
                else
                    op = 2'($urandom_range(1, 3));
                send_request(op, $urandom, pick_prio());
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 12));
        end
        in_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (2 * DEPTH + 10) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #10000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
